>>> hdl/e2r_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the Euler angle to
// rotation matrix pipeline. No dependencies.
package e2r_pkg;

   // Output entries are Q1.OUT_FRAC_BITS; internal math runs in Q30.
   localparam int OUT_FRAC_BITS = 15;
   localparam int OUT_SHIFT     = 30 - OUT_FRAC_BITS;
   localparam logic [34:0] OUT_RND = 35'((64'd1 << OUT_SHIFT) >> 1);

   localparam logic [30:0] QONE      = 31'h4000_0000;
   localparam logic [61:0] QHALF     = 62'h2000_0000;
   localparam logic [18:0] TURN      = 19'd46080;
   localparam logic [15:0] QUARTER   = 16'd11520;
   localparam logic [13:0] EIGHTH    = 14'd5760;
   localparam logic [27:0] RAD_Q40   = 28'd149922641;

   // Stage counts: angle unit, matrix unit (last stage is the output register).
   localparam int SC_LAT = 14;
   localparam int MX_LAT = 4;
   localparam int LAT    = SC_LAT + MX_LAT;

   // Series divisors and floor(2^32 / d) reciprocals, one per Horner step.
   localparam logic [5:0]  SIN_DIV_D [3] = '{6'd42, 6'd20, 6'd6};
   localparam logic [29:0] SIN_DIV_M [3] = '{30'd102261126, 30'd214748364, 30'd715827882};
   localparam logic [5:0]  COS_DIV_D [3] = '{6'd56, 6'd30, 6'd12};
   localparam logic [29:0] COS_DIV_M [3] = '{30'd76695844, 30'd143165576, 30'd357913941};

   typedef struct packed {
      logic [29:0] x;
      logic [29:0] x2;
      logic [1:0]  quad;
      logic        swap;
   } sc_ctx_type;

   // Unsigned Q30 product, rounded.
   function automatic logic [30:0] umul(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] p;
      p = 62'(a) * 62'(b) + QHALF;
      return p[60:30];
   endfunction

   // Signed Q30 product, rounded on the magnitude.
   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic        neg;
      logic [31:0] ua;
      logic [31:0] ub;
      logic [30:0] p;
      neg = a[31] ^ b[31];
      ua  = a[31] ? 32'(-a) : 32'(a);
      ub  = b[31] ? 32'(-b) : 32'(b);
      p   = umul(ua[30:0], ub[30:0]);
      return neg ? -signed'({1'b0, p}) : signed'({1'b0, p});
   endfunction

   // Q30 sum to Q1.OUT_FRAC_BITS, round half away from zero, saturate.
   function automatic logic [15:0] to_out(input logic signed [33:0] v);
      logic        neg;
      logic [34:0] m;
      logic [15:0] res;
      neg = v[33];
      m   = neg ? 35'(-v) : 35'(v);
      m   = (m + OUT_RND) >> OUT_SHIFT;
      if (neg) begin
         res = (m > 35'd32768) ? 16'h8000 : 16'(-m);
      end else begin
         res = (m > 35'd32767) ? 16'h7fff : m[15:0];
      end
      return res;
   endfunction

endpackage

>>> hdl/e2r_sincos.sv
`timescale 1ns / 1ps
// Pipelined sine/cosine of one angle in 1/128 degree, Q30 results.
// Depends on e2r_pkg. Advances when en is high.
module e2r_sincos
   import e2r_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [16:0]        angle,
   output logic signed [31:0] sin_o,
   output logic signed [31:0] cos_o
);

   logic [15:0] u_ff;
   logic [1:0]  quad_ff;
   logic [12:0] rr_ff;
   logic        swap_ff;
   logic [1:0]  quad3_ff;
   logic        swap3_ff;
   logic [29:0] x3_ff;
   sc_ctx_type  ctx_ff [10];

   logic [27:0] q0s_ff [3];
   logic [27:0] q0c_ff [3];
   logic [29:0] ns_ff  [3];
   logic [29:0] nc_ff  [3];
   logic [30:0] ts_ff  [3];
   logic [30:0] tc_ff  [3];
   logic [29:0] uns_ff [3];
   logic [29:0] unc_ff [3];

   logic signed [31:0] sin_ff;
   logic signed [31:0] cos_ff;

   logic [18:0] v_in;
   logic [18:0] u_in;
   logic [15:0] r_in;
   logic [1:0]  quad_in;
   logic [40:0] xp_in;

   // reduce to one turn, then to quadrant and octant
   always_comb begin
      v_in = {{2{angle[16]}}, angle} + 19'd92160;
      if (v_in >= 3 * TURN)      u_in = v_in - 19'(3 * TURN);
      else if (v_in >= 2 * TURN) u_in = v_in - 19'(2 * TURN);
      else if (v_in >= TURN)     u_in = v_in - TURN;
      else                       u_in = v_in;
      if (u_ff >= 16'(3 * QUARTER)) begin
         quad_in = 2'd3;
         r_in    = u_ff - 16'(3 * QUARTER);
      end else if (u_ff >= 16'(2 * QUARTER)) begin
         quad_in = 2'd2;
         r_in    = u_ff - 16'(2 * QUARTER);
      end else if (u_ff >= QUARTER) begin
         quad_in = 2'd1;
         r_in    = u_ff - QUARTER;
      end else begin
         quad_in = 2'd0;
         r_in    = u_ff;
      end
      xp_in = 41'(rr_ff) * 41'(RAD_Q40) + 41'd512;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff    <= u_in[15:0];
         quad_ff <= quad_in;
         swap_ff <= r_in[13:0] > EIGHTH;
         rr_ff   <= (r_in[13:0] > EIGHTH) ? 13'(QUARTER - r_in) : r_in[12:0];
         quad3_ff <= quad_ff;
         swap3_ff <= swap_ff;
         x3_ff    <= xp_in[39:10];
         ctx_ff[0].x    <= x3_ff;
         ctx_ff[0].x2   <= 30'(umul({1'b0, x3_ff}, {1'b0, x3_ff}));
         ctx_ff[0].quad <= quad3_ff;
         ctx_ff[0].swap <= swap3_ff;
         for (int i = 1; i < 10; i++) begin
            ctx_ff[i] <= ctx_ff[i-1];
         end
      end
   end

   // Horner steps: multiply by reciprocal, correct quotient, then rescale.
   for (genvar k = 0; k < 3; k++) begin : g_step
      logic [29:0] nums_in;
      logic [29:0] numc_in;
      logic [59:0] ps_in;
      logic [59:0] pc_in;
      logic [30:0] rems_in;
      logic [30:0] remc_in;
      logic [27:0] qs_in;
      logic [27:0] qc_in;
      logic [30:0] mul_s_in;

      if (k == 0) begin : g_first
         assign nums_in = ctx_ff[0].x2;
         assign numc_in = ctx_ff[0].x2;
      end else begin : g_next
         assign nums_in = uns_ff[k-1];
         assign numc_in = unc_ff[k-1];
      end

      // the final sine step scales by x, every other step by x^2
      if (k == 2) begin : g_last
         assign mul_s_in = {1'b0, ctx_ff[3*k+2].x};
      end else begin : g_mid
         assign mul_s_in = {1'b0, ctx_ff[3*k+2].x2};
      end

      always_comb begin
         ps_in   = 60'(nums_in) * 60'(SIN_DIV_M[k]);
         pc_in   = 60'(numc_in) * 60'(COS_DIV_M[k]);
         rems_in = 31'(ns_ff[k]) - 31'(q0s_ff[k]) * 31'(SIN_DIV_D[k]);
         remc_in = 31'(nc_ff[k]) - 31'(q0c_ff[k]) * 31'(COS_DIV_D[k]);
         qs_in   = q0s_ff[k] + 28'(rems_in >= 31'(SIN_DIV_D[k]));
         qc_in   = q0c_ff[k] + 28'(remc_in >= 31'(COS_DIV_D[k]));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q0s_ff[k] <= ps_in[59:32];
            q0c_ff[k] <= pc_in[59:32];
            ns_ff[k]  <= nums_in;
            nc_ff[k]  <= numc_in;
            ts_ff[k]  <= QONE - 31'(qs_in);
            tc_ff[k]  <= QONE - 31'(qc_in);
            uns_ff[k] <= 30'(umul(mul_s_in, ts_ff[k]));
            unc_ff[k] <= 30'(umul({1'b0, ctx_ff[3*k+2].x2}, tc_ff[k]));
         end
      end
   end

   logic [30:0] s0_in;
   logic [30:0] c0_in;
   logic signed [31:0] ss_in;
   logic signed [31:0] cc_in;
   logic signed [31:0] sin_in;
   logic signed [31:0] cos_in;

   always_comb begin
      s0_in = {1'b0, uns_ff[2]};
      c0_in = QONE - {2'b0, unc_ff[2][29:1]};
      if (ctx_ff[9].swap) begin
         ss_in = signed'({1'b0, c0_in});
         cc_in = signed'({1'b0, s0_in});
      end else begin
         ss_in = signed'({1'b0, s0_in});
         cc_in = signed'({1'b0, c0_in});
      end
      case (ctx_ff[9].quad)
         2'd0: begin
            sin_in = ss_in;
            cos_in = cc_in;
         end
         2'd1: begin
            sin_in = cc_in;
            cos_in = -ss_in;
         end
         2'd2: begin
            sin_in = -ss_in;
            cos_in = -cc_in;
         end
         default: begin
            sin_in = -cc_in;
            cos_in = ss_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;

endmodule

>>> hdl/e2r_matrix.sv
`timescale 1ns / 1ps
// Rotation matrix yaw * pitch * roll from Q30 sines and cosines, to Q1.15.
// Depends on e2r_pkg. Four stages, the last one drives the result beat.
module e2r_matrix
   import e2r_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] sp,
   input  logic signed [31:0] cp,
   input  logic signed [31:0] sy,
   input  logic signed [31:0] cy,
   input  logic signed [31:0] sr,
   input  logic signed [31:0] cr,
   output logic [8:0][15:0]   mat
);

   logic signed [31:0] srsp_ff;
   logic signed [31:0] crsp_ff;
   logic signed [31:0] cy1_ff;
   logic signed [31:0] sy1_ff;
   logic signed [31:0] sp1_ff;
   // cpcy, crsy, srsy, cpsy, crcy, srcy, srcp, crcp
   logic signed [31:0] p1_ff [8];
   logic signed [31:0] p2_ff [8];
   logic signed [31:0] sp2_ff;
   // srsp*cy, crsp*cy, srsp*sy, crsp*sy
   logic signed [31:0] t_ff  [4];
   logic signed [33:0] sum_ff [9];
   logic [8:0][15:0]   mat_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         srsp_ff  <= qmul(sr, sp);
         crsp_ff  <= qmul(cr, sp);
         cy1_ff   <= cy;
         sy1_ff   <= sy;
         sp1_ff   <= sp;
         p1_ff[0] <= qmul(cp, cy);
         p1_ff[1] <= qmul(cr, sy);
         p1_ff[2] <= qmul(sr, sy);
         p1_ff[3] <= qmul(cp, sy);
         p1_ff[4] <= qmul(cr, cy);
         p1_ff[5] <= qmul(sr, cy);
         p1_ff[6] <= qmul(sr, cp);
         p1_ff[7] <= qmul(cr, cp);

         t_ff[0] <= qmul(srsp_ff, cy1_ff);
         t_ff[1] <= qmul(crsp_ff, cy1_ff);
         t_ff[2] <= qmul(srsp_ff, sy1_ff);
         t_ff[3] <= qmul(crsp_ff, sy1_ff);
         p2_ff   <= p1_ff;
         sp2_ff  <= sp1_ff;

         sum_ff[0] <= 34'(p2_ff[0]);
         sum_ff[1] <= 34'(t_ff[0]) - 34'(p2_ff[1]);
         sum_ff[2] <= 34'(t_ff[1]) + 34'(p2_ff[2]);
         sum_ff[3] <= 34'(p2_ff[3]);
         sum_ff[4] <= 34'(t_ff[2]) + 34'(p2_ff[4]);
         sum_ff[5] <= 34'(t_ff[3]) - 34'(p2_ff[5]);
         sum_ff[6] <= -34'(sp2_ff);
         sum_ff[7] <= 34'(p2_ff[6]);
         sum_ff[8] <= 34'(p2_ff[7]);

         for (int i = 0; i < 9; i++) begin
            mat_ff[i] <= to_out(sum_ff[i]);
         end
      end
   end

   assign mat = mat_ff;

endmodule

>>> hdl/euler_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Top level: Euler angles plus translation in, 3x4 pose matrix out.
// Depends on e2r_pkg, e2r_sincos and e2r_matrix.
//
//  channel  dir  tdata fields (low bit first)
//  req_     in   pitch[17] yaw[17] roll[17] pos_x[32] pos_y[32] pos_z[32] pad[5]
//  rsp_     out  m00..m22[16 each, row major] m03[32] m13[32] m23[32]
//
// One beat per cycle while no result beat stalls; the sine/cosine series
// unit feeds the matrix products and output rounding.
// Reset clears the stage valid bits only.
// A stalled result beat freezes every stage; req_tready drops with it.
module euler_to_rotation_matrix
   import e2r_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [151:0] req_tdata,  // pitch, yaw, roll, pos_x, pos_y, pos_z, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [239:0] rsp_tdata   // m00,m01,m02,m10,m11,m12,m20,m21,m22,m03,m13,m23
);

   logic              en;
   logic [LAT-1:0]    vld_ff;
   logic [95:0]       pos_ff [LAT];
   logic signed [31:0] sin_w [3];
   logic signed [31:0] cos_w [3];
   logic [8:0][15:0]  mat_w;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // translation rides alongside the math
   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[0] <= req_tdata[146:51];
         for (int i = 1; i < LAT; i++) begin
            pos_ff[i] <= pos_ff[i-1];
         end
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_angle
      e2r_sincos u_sincos (
         .clock (clock),
         .en    (en),
         .angle (req_tdata[17*a +: 17]),
         .sin_o (sin_w[a]),
         .cos_o (cos_w[a])
      );
   end

   e2r_matrix u_matrix (
      .clock (clock),
      .en    (en),
      .sp    (sin_w[0]),
      .cp    (cos_w[0]),
      .sy    (sin_w[1]),
      .cy    (cos_w[1]),
      .sr    (sin_w[2]),
      .cr    (cos_w[2]),
      .mat   (mat_w)
   );

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {pos_ff[LAT-1], mat_w};

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted beat missing from first stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && vld_ff == '0)
      else $error("valid bits survive reset");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !vld_ff[LAT-2] |=> !rsp_tvalid)
      else $error("result beat repeated");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Stream testbench for euler_to_rotation_matrix: directed table, then random
// angle/translation beats, scored against an in-bench fixed-point predictor.
// Depends on e2r_pkg and the DUT sources.
module testbench
   import e2r_pkg::*;
();

   localparam int N_RANDOM = 1850;
   localparam logic [16:0] ANG_MIN = 17'h10000;
   localparam logic [16:0] ANG_MAX = 17'h0ffff;

   typedef struct packed {
      logic [31:0] pz;
      logic [31:0] py;
      logic [31:0] px;
      logic [16:0] roll;
      logic [16:0] yaw;
      logic [16:0] pitch;
   } pose_in_type;

   typedef struct {
      pose_in_type pose;
      logic        has_gold;
      logic [15:0] gold_m00;   // typed-in m00 where obvious
      logic [15:0] gold_m20;
   } dir_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [151:0] req_tdata;   // pitch, yaw, roll, pos_x, pos_y, pos_z, pad
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [239:0] rsp_tdata;   // m00..m22 (16 each), m03, m13, m23 (32 each)

   logic [239:0] matrix_queue [$];
   logic [15:0]  gold_m00_q [$];
   logic [15:0]  gold_m20_q [$];
   logic         gold_en_q [$];
   int           n_errors;
   int           hold_cycles;
   bit           hold_req;
   bit           hold_done;
   bit           quiet_rx;

   euler_to_rotation_matrix DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("testbench: errors");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic logic [63:0] rmul(logic [63:0] a, logic [63:0] b);
      return (a * b + 64'h2000_0000) >> 30;
   endfunction

   function automatic longint smul(longint a, longint b);
      logic        neg;
      logic [63:0] ua, ub, p;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = rmul(ua, ub);
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic void octant(input logic [63:0] r, output logic [63:0] s,
                                  output logic [63:0] c);
      logic [63:0] x, x2, t, one;
      one = 64'd1 << 30;
      x = (r * 64'd149922641 + 64'd512) >> 10;
      x2 = rmul(x, x);
      t = one - x2 / 42;
      t = one - rmul(x2, t) / 20;
      t = one - rmul(x2, t) / 6;
      s = rmul(x, t);
      t = one - x2 / 56;
      t = one - rmul(x2, t) / 30;
      t = one - rmul(x2, t) / 12;
      c = one - rmul(x2, t) / 2;
   endfunction

   function automatic void angle_sincos(input logic [16:0] ang, output longint s,
                                        output longint c);
      longint      a, u, q, r;
      logic [63:0] s0, c0;
      a = longint'($signed(ang));
      u = (a + 2 * 46080) % 46080;
      q = u / 11520;
      r = u % 11520;
      if (r > 5760) octant(11520 - r, c0, s0);
      else octant(r, s0, c0);
      case (q)
         0: begin s = s0; c = c0; end
         1: begin s = c0; c = -longint'(s0); end
         2: begin s = -longint'(s0); c = -longint'(c0); end
         default: begin s = -longint'(c0); c = s0; end
      endcase
   endfunction

   function automatic logic [15:0] q15_sat(longint v);
      logic        neg;
      logic [63:0] m;
      neg = v < 0;
      m = neg ? -v : v;
      m = (m + (64'd1 << 14)) >> 15;
      if (neg) return m > 32768 ? 16'h8000 : 16'(-m);
      return m > 32767 ? 16'h7fff : m[15:0];
   endfunction

   function automatic logic [239:0] pose_matrix(pose_in_type p);
      longint sp, cp, sy, cy, sr, cr, srsp, crsp;
      angle_sincos(p.pitch, sp, cp);
      angle_sincos(p.yaw, sy, cy);
      angle_sincos(p.roll, sr, cr);
      srsp = smul(sr, sp);
      crsp = smul(cr, sp);
      return {p.pz, p.py, p.px,
              q15_sat(smul(cr, cp)), q15_sat(smul(sr, cp)), q15_sat(-sp),
              q15_sat(smul(crsp, sy) - smul(sr, cy)),
              q15_sat(smul(srsp, sy) + smul(cr, cy)),
              q15_sat(smul(cp, sy)),
              q15_sat(smul(crsp, cy) + smul(sr, sy)),
              q15_sat(smul(srsp, cy) - smul(cr, sy)),
              q15_sat(smul(cp, cy))};
   endfunction

   // ---------------- checker / receiver ----------------
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready && !reset) begin
         if (matrix_queue.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, rsp_tdata);
            n_errors++;
         end else begin
            logic [239:0] e;
            logic         g;
            logic [15:0]  g0, g6;
            e = matrix_queue.pop_front();
            g = gold_en_q.pop_front();
            g0 = gold_m00_q.pop_front();
            g6 = gold_m20_q.pop_front();
            for (int f = 0; f < 9; f++)
               if (rsp_tdata[f*16 +: 16] !== e[f*16 +: 16]) begin
                  $display("%0t: m%0d%0d expected %h actual %h", $time, f / 3, f % 3,
                           e[f*16 +: 16], rsp_tdata[f*16 +: 16]);
                  n_errors++;
               end
            for (int f = 0; f < 3; f++)
               if (rsp_tdata[144 + f*32 +: 32] !== e[144 + f*32 +: 32]) begin
                  $display("%0t: m%0d3 expected %h actual %h", $time, f,
                           e[144 + f*32 +: 32], rsp_tdata[144 + f*32 +: 32]);
                  n_errors++;
               end
            if (g && (rsp_tdata[15:0] !== g0 || rsp_tdata[111:96] !== g6)) begin
               $display("%0t: table m00/m20 expected %h/%h actual %h/%h", $time, g0, g6,
                        rsp_tdata[15:0], rsp_tdata[111:96]);
               n_errors++;
            end
         end
      end
      if (reset) rsp_tready <= 1'b0;
      else if (hold_req && !hold_done) begin
         // long hold-off, counted here
         hold_cycles = 200;
         hold_done = 1'b1;
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else rsp_tready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 31);
   end

   // ---------------- sender ----------------
   task automatic send_pose(pose_in_type p, bit gold, logic [15:0] g0, logic [15:0] g6,
                            bit may_idle);
      if (may_idle)
         while ($urandom_range(99) < 31) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, p};
      matrix_queue.push_back(pose_matrix(p));
      gold_en_q.push_back(gold);
      gold_m00_q.push_back(g0);
      gold_m20_q.push_back(g6);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [16:0] rand_angle();
      case ($urandom_range(9))
         0: return 17'($urandom_range(3) * 11520 + $urandom_range(2) + 5759);
         1: return 17'($urandom_range(7) * 5760) ^ 17'($urandom_range(1));
         2: return 17'($urandom);
         default: return 17'($signed(32'($urandom_range(92159)) - 32'sd46080));
      endcase
   endfunction

   dir_row_type dir_table [$];

   initial begin
      pose_in_type p;
      n_errors = 0;
      hold_req = 1'b0;
      quiet_rx = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      // zero angles: identity, m00 saturates to 32767, m20 = 0
      dir_table.push_back('{'{32'h0, 32'h0, 32'h0, 17'd0, 17'd0, 17'd0}, 1, 16'h7fff, 16'h0000});
      dir_table.push_back('{'{32'hffffffff, 32'h80000000, 32'h7fffffff, 17'd0, 17'd0, 17'd0},
                            1, 16'h7fff, 16'h0000});
      // pitch +90: m00 = 0, m20 = -1
      dir_table.push_back('{'{32'h1, 32'h2, 32'h3, 17'd0, 17'd0, 17'd11520}, 1, 16'h0000, 16'h8000});
      dir_table.push_back('{'{32'h0, 32'h0, 32'h0, 17'd0, 17'd0, 17'h1d300}, 1, 16'h0000, 16'h7fff});
      // pitch 180: m00 = -1
      dir_table.push_back('{'{32'h0, 32'h0, 32'h0, 17'd0, 17'd0, 17'd23040}, 1, 16'h8000, 16'h0000});
      // full turn wraps to zero
      dir_table.push_back('{'{32'h0, 32'h0, 32'h0, 17'd46080, 17'd46080, 17'd46080},
                            1, 16'h7fff, 16'h0000});
      dir_table.push_back('{'{32'h0, 32'h0, 32'h0, ANG_MIN, ANG_MAX, ANG_MIN}, 0, 0, 0});
      dir_table.push_back('{'{32'h0, 32'h0, 32'h0, ANG_MAX, ANG_MIN, ANG_MAX}, 0, 0, 0});
      dir_table.push_back('{'{32'h5, 32'h6, 32'h7, 17'd5760, 17'd5761, 17'd5759}, 0, 0, 0});
      dir_table.push_back('{'{32'h0, 32'h0, 32'h0, 17'd17280, 17'd34560, 17'd40320}, 0, 0, 0});
      dir_table.push_back('{'{32'hdeadbeef, 32'h0, 32'h0, 17'd1, 17'h1ffff, 17'd11519}, 0, 0, 0});
      dir_table.push_back('{'{32'h0, 32'h0, 32'h0, 17'd11521, 17'd23039, 17'd34561}, 0, 0, 0});
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_table[i])
         send_pose(dir_table[i].pose, dir_table[i].has_gold, dir_table[i].gold_m00,
                   dir_table[i].gold_m20, 1);
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 300) begin
            // long receiver hold-off while the sender keeps offering beats
            hold_req <= 1'b1;
         end
         if (n == 600) begin
            // sender pauses until the pipe drains
            req_tvalid <= 1'b0;
            while (matrix_queue.size() != 0) @(posedge clock);
         end
         if (n == 900) quiet_rx <= 1'b1;
         if (n == 1300) quiet_rx <= 1'b0;
         p.pitch = rand_angle();
         p.yaw = rand_angle();
         p.roll = rand_angle();
         p.px = $urandom;
         p.py = $urandom;
         p.pz = $urandom;
         send_pose(p, 0, 0, 0, !(n >= 900 && n < 1300));
      end
      req_tvalid <= 1'b0;
      while (matrix_queue.size() != 0) @(posedge clock);
      repeat (LAT + 10) @(posedge clock);
      if (n_errors == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule
